@@ hw/rtl/deq_pkg.sv @@
// shared constants, types and helpers for the double-ended queue unit
package deq_pkg;

  localparam int DATA_W   = 32;
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SIZE       = 3'd4,
    OP_EMPTY      = 3'd5,
    OP_FRONT      = 3'd6,
    OP_BACK       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic mem_reply;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mem_op;
  } dp_status_t;

  // fold a position below twice the capacity back into the ring
  function automatic logic [ADDR_W-1:0] wrap_slot(input logic [CNT_W:0] pos);
    logic [CNT_W:0] cap;
    cap = (CNT_W + 1)'(CAPACITY);
    if (pos >= cap) begin
      return ADDR_W'(pos - cap);
    end
    return ADDR_W'(pos);
  endfunction

endpackage

@@ hw/rtl/deq_ram.sv @@
// generic single-port ram with registered read
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// controller state machine for the double-ended queue unit
module deq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  deq_pkg::dp_status_t   status,
  output deq_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);

  deq_pkg::state_t state;
  deq_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = deq_pkg::ST_EXEC;
        end
      end
      deq_pkg::ST_EXEC: begin
        if (status.mem_op) begin
          state_next = deq_pkg::ST_READ;
        end else begin
          state_next = deq_pkg::ST_IDLE;
        end
      end
      deq_pkg::ST_READ: begin
        state_next = deq_pkg::ST_IDLE;
      end
      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      deq_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      deq_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      deq_pkg::ST_READ: begin
        cmd.mem_reply = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/deq_dp.sv @@
// datapath: item latch, ring pointers, slot ram and reply register
module deq_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  deq_pkg::ctrl_cmd_t                cmd,
  input  logic [2:0]                        opcode,
  input  logic signed [deq_pkg::DATA_W-1:0] push_value,
  output deq_pkg::dp_status_t               status,
  output logic                              done,
  output logic signed [deq_pkg::DATA_W-1:0] reply_value
);

  deq_pkg::op_t                 op;
  logic [deq_pkg::DATA_W-1:0]   value;
  logic [deq_pkg::ADDR_W-1:0]   head;
  logic [deq_pkg::ADDR_W-1:0]   head_next;
  logic [deq_pkg::CNT_W-1:0]    count;
  logic [deq_pkg::CNT_W-1:0]    count_next;

  logic                         is_empty;
  logic                         is_full;
  logic                         is_push;
  logic                         is_fetch;
  logic [deq_pkg::ADDR_W-1:0]   head_inc;
  logic [deq_pkg::ADDR_W-1:0]   head_dec;
  logic [deq_pkg::CNT_W:0]      end_pos;
  logic [deq_pkg::ADDR_W-1:0]   back_slot;
  logic [deq_pkg::ADDR_W-1:0]   tail_slot;
  logic [deq_pkg::ADDR_W-1:0]   ram_addr;
  logic                         ram_we;
  logic [deq_pkg::DATA_W-1:0]   ram_rdata;
  logic [deq_pkg::DATA_W-1:0]   direct_reply;

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= deq_pkg::op_t'(opcode);
      value <= push_value;
    end
  end

  // occupancy and op class
  assign is_empty = (count == '0);
  assign is_full  = (count == deq_pkg::CNT_W'(deq_pkg::CAPACITY));
  assign is_push  = (op == deq_pkg::OP_PUSH_FRONT) || (op == deq_pkg::OP_PUSH_BACK);
  assign is_fetch = (op == deq_pkg::OP_POP_FRONT) || (op == deq_pkg::OP_POP_BACK) ||
                    (op == deq_pkg::OP_FRONT) || (op == deq_pkg::OP_BACK);
  assign status.mem_op = is_fetch && !is_empty;

  // ring slot arithmetic
  assign head_inc  = (head == deq_pkg::ADDR_W'(deq_pkg::CAPACITY - 1)) ? '0 : head + 1'b1;
  assign head_dec  = (head == '0) ? deq_pkg::ADDR_W'(deq_pkg::CAPACITY - 1) : head - 1'b1;
  assign end_pos   = (deq_pkg::CNT_W + 1)'(head) + (deq_pkg::CNT_W + 1)'(count);
  assign back_slot = deq_pkg::wrap_slot(end_pos);
  // tail only used when the queue holds at least one element
  assign tail_slot = deq_pkg::wrap_slot(end_pos - 1'b1);

  // slot address by opcode
  always_comb begin
    case (op)
      deq_pkg::OP_PUSH_FRONT: ram_addr = head_dec;
      deq_pkg::OP_PUSH_BACK:  ram_addr = back_slot;
      deq_pkg::OP_POP_BACK:   ram_addr = tail_slot;
      deq_pkg::OP_BACK:       ram_addr = tail_slot;
      default:                ram_addr = head;
    endcase
  end

  assign ram_we = cmd.exec && is_push && !is_full;

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (deq_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value),
    .rdata (ram_rdata)
  );

  // pointer updates
  always_comb begin
    head_next  = head;
    count_next = count;
    if (cmd.exec) begin
      case (op)
        deq_pkg::OP_PUSH_FRONT: begin
          if (!is_full) begin
            head_next  = head_dec;
            count_next = count + 1'b1;
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (!is_full) begin
            count_next = count + 1'b1;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (!is_empty) begin
            head_next  = head_inc;
            count_next = count - 1'b1;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (!is_empty) begin
            count_next = count - 1'b1;
          end
        end
        default: begin
          head_next  = head;
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // replies that need no slot read
  always_comb begin
    case (op)
      deq_pkg::OP_SIZE:  direct_reply = deq_pkg::DATA_W'(count);
      deq_pkg::OP_EMPTY: direct_reply = deq_pkg::DATA_W'(is_empty);
      default:           direct_reply = '1;
    endcase
  end

  // reply register and strobe
  always_ff @(posedge clk) begin
    if (cmd.mem_reply) begin
      reply_value <= ram_rdata;
    end else if (cmd.exec) begin
      reply_value <= direct_reply;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.mem_reply || (cmd.exec && !is_push && !status.mem_op);
    end
  end

endmodule

@@ hw/rtl/double_ended_queue_unit.sv @@
// top level of the double-ended queue unit
// push items hold busy for 1 cycle and give no result
// size, empty and any pop or peek on an empty queue: done set from the exec state
// pop or peek on a non-empty queue: done after exec and read states (registered ram read)
// one item at a time; the result strobe can overlap the next accept
// reset clears head, count, done and state; slot ram contents are left as they are
module double_ended_queue_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        opcode,
  input  logic signed [deq_pkg::DATA_W-1:0] push_value,
  output logic                              done,
  output logic signed [deq_pkg::DATA_W-1:0] reply_value
);

  deq_pkg::ctrl_cmd_t  cmd;
  deq_pkg::dp_status_t status;

  deq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  deq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (opcode),
    .push_value  (push_value),
    .status      (status),
    .done        (done),
    .reply_value (reply_value)
  );

endmodule

@@ hw/rtl/deq_checker.sv @@
// port-level checker for the double-ended queue unit, bound to the top level
module deq_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted item keeps the unit busy in the next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("unit not busy after item accepted");

  // busy only rises on an accepted item
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("busy rose without an item");

  // a result strobe lasts one cycle
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held");

  // the result shows once the unit has gone idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");

  // no result in the cycle right after an accept
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> !done)
    else $error("result too early after accept");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
